// File: sv/agr_pkg.sv
package agr_pkg;

    // Frame geometry and field values
    localparam int unsigned ARP_FRAME_LEN = 42;
    localparam int unsigned POS_W         = 6;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(ARP_FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_SAT  = POS_W'(ARP_FRAME_LEN);

    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] HTYPE_ETH      = 16'h0001;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
    localparam logic [7:0]  ARP_HLEN       = 8'd6;
    localparam logic [7:0]  ARP_PLEN       = 8'd4;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_DATA_W = 48;
    localparam logic CFG_GATEWAY_IP  = 1'b0;
    localparam logic CFG_GATEWAY_MAC = 1'b1;
    localparam logic [31:0] GATEWAY_IP_RESET  = 32'h0A00_0202;
    localparam logic [47:0] GATEWAY_MAC_RESET = 48'h5254_0012_3456;

    // Default depth of the reply queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // One pending reply: what the requester supplied
    typedef struct packed {
        logic [47:0] requester_mac;
        logic [31:0] requester_ip;
    } agr_reply_t;

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
        return 8'(mac >> {(3'd5 - i), 3'b000});
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
        return 8'(ip >> {(2'd3 - i), 3'b000});
    endfunction

    // Byte p of the reply frame in wire order
    function automatic logic [7:0] reply_at(
        input logic [POS_W-1:0] p,
        input agr_reply_t       rep,
        input logic [31:0]      gw_ip,
        input logic [47:0]      gw_mac
    );
        logic [POS_W-1:0] off;
        logic [7:0]       b;
        off = '0;
        b   = '0;
        case (p) inside
            [6'd0:6'd5]: begin
                b = mac_byte(rep.requester_mac, p[2:0]);
            end
            [6'd6:6'd11]: begin
                off = p - 6'd6;
                b = mac_byte(gw_mac, off[2:0]);
            end
            6'd12: b = ETYPE_ARP[15:8];
            6'd13: b = ETYPE_ARP[7:0];
            6'd14: b = HTYPE_ETH[15:8];
            6'd15: b = HTYPE_ETH[7:0];
            6'd16: b = ETYPE_IPV4[15:8];
            6'd17: b = ETYPE_IPV4[7:0];
            6'd18: b = ARP_HLEN;
            6'd19: b = ARP_PLEN;
            6'd20: b = ARP_OP_REPLY[15:8];
            6'd21: b = ARP_OP_REPLY[7:0];
            [6'd22:6'd27]: begin
                off = p - 6'd22;
                b = mac_byte(gw_mac, off[2:0]);
            end
            [6'd28:6'd31]: begin
                off = p - 6'd28;
                b = ip_byte(gw_ip, off[1:0]);
            end
            [6'd32:6'd37]: begin
                off = p - 6'd32;
                b = mac_byte(rep.requester_mac, off[2:0]);
            end
            default: begin
                off = p - 6'd38;
                b = ip_byte(rep.requester_ip, off[1:0]);
            end
        endcase
        return b;
    endfunction

endpackage

// File: sv/agr_front.sv
module agr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_frame_byte,
    input  logic              s_last_byte,
    input  logic [31:0]       gateway_ip,
    input  logic              q_full,
    output logic              q_push,
    output agr_pkg::agr_reply_t q_wdata
);
    import agr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      type_reg, type_next;
    logic [15:0]      oper_reg, oper_next;
    logic [47:0]      mac_reg, mac_next;
    logic [31:0]      sip_reg, sip_next;
    logic [31:0]      tip_reg, tip_next;
    logic             accept;
    logic             match;

    // A request is taken whenever the queue has room for a reply
    assign s_ready = ~q_full;
    assign accept  = s_valid & s_ready;

    // Capture the header fields by byte position
    always_comb begin
        type_next = type_reg;
        oper_next = oper_reg;
        mac_next  = mac_reg;
        sip_next  = sip_reg;
        tip_next  = tip_reg;
        case (pos_reg) inside
            [6'd12:6'd13]: type_next = {type_reg[7:0], s_frame_byte};
            [6'd20:6'd21]: oper_next = {oper_reg[7:0], s_frame_byte};
            [6'd22:6'd27]: mac_next  = {mac_reg[39:0], s_frame_byte};
            [6'd28:6'd31]: sip_next  = {sip_reg[23:0], s_frame_byte};
            [6'd38:6'd41]: tip_next  = {tip_reg[23:0], s_frame_byte};
            default: ;
        endcase
        pos_next = (pos_reg < POS_SAT) ? pos_reg + 1'b1 : pos_reg;
    end

    // Classify the frame on its last byte
    assign match = (pos_next == POS_SAT) && (type_next == ETYPE_ARP) &&
                   (oper_next == ARP_OP_REQUEST) && (tip_next == gateway_ip);

    assign q_push                = accept & s_last_byte & match;
    assign q_wdata.requester_mac = mac_next;
    assign q_wdata.requester_ip  = sip_next;

    // Parser state; cleared at the end of every frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            type_reg <= '0;
            oper_reg <= '0;
            mac_reg  <= '0;
            sip_reg  <= '0;
            tip_reg  <= '0;
        end else if (accept) begin
            if (s_last_byte) begin
                pos_reg  <= '0;
                type_reg <= '0;
                oper_reg <= '0;
                mac_reg  <= '0;
                sip_reg  <= '0;
                tip_reg  <= '0;
            end else begin
                pos_reg  <= pos_next;
                type_reg <= type_next;
                oper_reg <= oper_next;
                mac_reg  <= mac_next;
                sip_reg  <= sip_next;
                tip_reg  <= tip_next;
            end
        end
    end

endmodule

// File: sv/agr_queue.sv
module agr_queue #(
    parameter int unsigned DEPTH = agr_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  agr_pkg::agr_reply_t wdata,
    input  logic                pop,
    output agr_pkg::agr_reply_t rdata,
    output logic                full,
    output logic                empty
);
    import agr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    agr_reply_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Pointer and fill count updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/agr_back.sv
module agr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  agr_pkg::agr_reply_t q_rdata,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic [31:0]         gateway_ip,
    input  logic [47:0]         gateway_mac,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_reply_byte,
    output logic                m_reply_last
);
    import agr_pkg::*;

    logic [POS_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             load;
    logic             at_end;

    // The output register takes a new byte when empty or being drained
    assign load   = ~valid_reg | m_ready;
    assign at_end = (idx_reg == POS_LAST);
    assign q_pop  = load & ~q_empty & at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = ~q_empty;
            byte_next  = reply_at(idx_reg, q_rdata, gateway_ip, gateway_mac);
            last_next  = at_end;
            if (!q_empty) begin
                idx_next = at_end ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Payload of the output register
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid      = valid_reg;
    assign m_reply_byte = byte_reg;
    assign m_reply_last = last_reg;

endmodule

// File: sv/arp_gateway_responder_unit.sv
// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+-------------------------------
// s_       | in        | s_valid / s_ready | s_frame_byte, s_last_byte
// m_       | out       | m_valid / m_ready | m_reply_byte, m_reply_last
// cfg_     | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// Frame bytes are taken at one per cycle; the parser holds s_ready low only
// while the reply queue is full.
// A matching request queues one 42-byte reply. Its first byte is offered after the
// queue count and output register update, then one byte per cycle unless stalled.
// Reset is synchronous and active low; it clears the parser, queue and output.
// A stall on m_ready holds the current reply byte and backs up into the queue.
module arp_gateway_responder_unit #(
    parameter int unsigned QUEUE_DEPTH = agr_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_frame_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_reply_byte,
    output logic                            m_reply_last,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [agr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import agr_pkg::*;

    logic [31:0] gw_ip_reg;
    logic [47:0] gw_mac_reg;
    agr_reply_t  q_wdata;
    agr_reply_t  q_rdata;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_ip_reg  <= GATEWAY_IP_RESET;
            gw_mac_reg <= GATEWAY_MAC_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GATEWAY_IP:  gw_ip_reg  <= cfg_wdata[31:0];
                CFG_GATEWAY_MAC: gw_mac_reg <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // Parser and classifier
    agr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_byte (s_frame_byte),
        .s_last_byte  (s_last_byte),
        .gateway_ip   (gw_ip_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    // Pending replies
    agr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Reply emitter
    agr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_rdata      (q_rdata),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .gateway_ip   (gw_ip_reg),
        .gateway_mac  (gw_mac_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reply_byte (m_reply_byte),
        .m_reply_last (m_reply_last)
    );

`ifndef SYNTHESIS
    // A reply is never queued into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("reply pushed into full queue");

    // A reply is only retired from a queue that holds one.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("reply popped from empty queue");

    // Retiring a reply coincides with loading its final byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (m_valid && m_reply_last))
        else $error("reply retired without final byte");
`endif

endmodule
